// ===== hw/rtl/cartesian_to_polar_vector_core_assert.svh =====
// assertion macros for the cartesian to polar vector core checker
// expects clk and rst_n in the scope of use
`ifndef CARTESIAN_TO_POLAR_VECTOR_CORE_ASSERT_SVH
`define CARTESIAN_TO_POLAR_VECTOR_CORE_ASSERT_SVH

// property holds at every clock outside reset
`define CTPV_ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// consequent holds in the cycle after the antecedent
`define CTPV_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/ctpv_pkg.sv =====
// types and constants for the cartesian to polar vector core
// no dependencies
package ctpv_pkg;

    localparam int COORD_W     = 16;
    localparam int MAG_W       = 17;
    localparam int ANGLE_W     = 16;
    localparam int PHASE_W     = 32;
    localparam int GUARD       = 24;
    localparam int DATA_W      = 44;
    localparam int MAG_SHIFT   = GUARD - 8;
    localparam int MAG_IN_W    = 26;
    localparam int GAIN_W      = 32;
    localparam int PROD_W      = MAG_IN_W + GAIN_W;
    localparam int ROUND_SHIFT = 40;

    localparam logic [GAIN_W-1:0]  INV_GAIN_Q32  = 32'd2608131497;
    localparam logic [MAG_W-1:0]   MAG_MAX       = 17'h1FFFF;
    localparam logic [ANGLE_W-1:0] ANGLE_QUARTER = 16'h4000;
    localparam logic [ANGLE_W-1:0] ANGLE_3QUART  = 16'hC000;
    localparam logic [PHASE_W-1:0] PHASE_HALF    = 32'h8000_0000;
    localparam logic [PHASE_W-1:0] PHASE_ROUND   = 32'h0000_8000;

    // atan(2^-i) as a fraction of a full turn, 2^32 per turn
    localparam logic [PHASE_W-1:0] ATAN_TURNS [0:31] = '{
        32'h20000000, 32'h12e4051e, 32'h09fb385b, 32'h051111d4,
        32'h028b0d43, 32'h0145d7e1, 32'h00a2f61e, 32'h00517c55,
        32'h0028be53, 32'h00145f2f, 32'h000a2f98, 32'h000517cc,
        32'h00028be6, 32'h000145f3, 32'h0000a2fa, 32'h0000517d,
        32'h000028be, 32'h0000145f, 32'h00000a30, 32'h00000518,
        32'h0000028c, 32'h00000146, 32'h000000a3, 32'h00000051,
        32'h00000029, 32'h00000014, 32'h0000000a, 32'h00000005,
        32'h00000003, 32'h00000001, 32'h00000001, 32'h00000000
    };

    typedef struct packed {
        logic signed [COORD_W-1:0] start_x;
        logic signed [COORD_W-1:0] start_y;
        logic signed [COORD_W-1:0] end_x;
        logic signed [COORD_W-1:0] end_y;
    } points_t;

    typedef struct packed {
        logic [MAG_W-1:0]   magnitude;
        logic [ANGLE_W-1:0] angle;
    } polar_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
        logic [PHASE_W-1:0]       phase;
        logic                     special;
        logic                     dy_pos;
        logic [MAG_W-1:0]         abs_dy;
    } cordic_t;

    typedef struct packed {
        logic [PROD_W-1:0]  prod;
        logic               big;
        logic [PHASE_W-1:0] phase;
        logic               special;
        logic               dy_pos;
        logic [MAG_W-1:0]   abs_dy;
    } mult_t;

endpackage

// ===== hw/rtl/cartesian_to_polar_vector_core.sv =====
// cartesian to polar vector core: pipelined cordic vectoring, length and direction
// depends on ctpv_pkg
//
// Takes one item per clock unless every stage is full and the output is stalled, and
// returns its length and direction through a register stage that forms the difference
// vector, one stage per cordic micro-rotation, one stage for the gain multiply and one
// output register. Each stage holds independently, so bubbles are squeezed out under a
// stall on the output side and the input keeps taking items while any stage is free.
module cartesian_to_polar_vector_core
    import ctpv_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    points_valid,
    output logic    points_ready,
    input  points_t points,
    output logic    polar_valid,
    input  logic    polar_ready,
    output polar_t  polar
);

    localparam int DEPTH   = CORDIC_STAGES + 3;
    localparam int MUL_IDX = CORDIC_STAGES + 1;
    localparam int OUT_IDX = CORDIC_STAGES + 2;

    logic [DEPTH-1:0] vld_reg;
    logic [DEPTH-1:0] vld_next;
    logic [DEPTH-1:0] en;

    cordic_t cor_reg [0:CORDIC_STAGES];
    cordic_t prep;
    mult_t   mul_reg;
    mult_t   mul_next;
    polar_t  polar_reg;
    polar_t  polar_next;

    // stage enables, a stage loads when empty or when its successor loads
    always_comb
    begin
        en[DEPTH-1] = !vld_reg[DEPTH-1] || polar_ready;
        for (int k = DEPTH - 2; k >= 0; k--)
        begin
            en[k] = !vld_reg[k] || en[k+1];
        end
        vld_next = (vld_reg & ~en) | ({vld_reg[DEPTH-2:0], points_valid} & en);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    // difference vector and half-turn fold
    logic signed [COORD_W:0] dx;
    logic signed [COORD_W:0] dy;
    logic signed [COORD_W:0] dxf;
    logic signed [COORD_W:0] dyf;
    logic                    dx_neg;

    always_comb
    begin
        dx     = {points.end_x[COORD_W-1], points.end_x} -
                 {points.start_x[COORD_W-1], points.start_x};
        dy     = {points.end_y[COORD_W-1], points.end_y} -
                 {points.start_y[COORD_W-1], points.start_y};
        dx_neg = dx[COORD_W];
        dxf    = dx_neg ? -dx : dx;
        dyf    = dx_neg ? -dy : dy;

        prep.x       = {{(DATA_W-COORD_W-1-GUARD){dxf[COORD_W]}}, dxf, {GUARD{1'b0}}};
        prep.y       = {{(DATA_W-COORD_W-1-GUARD){dyf[COORD_W]}}, dyf, {GUARD{1'b0}}};
        prep.phase   = dx_neg ? PHASE_HALF : '0;
        prep.special = (dx == '0);
        prep.dy_pos  = !dy[COORD_W] && (dy != '0);
        prep.abs_dy  = dy[COORD_W] ? MAG_W'(-dy) : MAG_W'(dy);
    end

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            cor_reg[0] <= prep;
        end
    end

    // one micro-rotation per stage
    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_stage
        logic signed [DATA_W-1:0] xs;
        logic signed [DATA_W-1:0] ys;
        cordic_t                  cor_next;

        always_comb
        begin
            xs       = cor_reg[i].x;
            ys       = cor_reg[i].y;
            cor_next = cor_reg[i];
            if (!ys[DATA_W-1])
            begin
                cor_next.x     = xs + (ys >>> i);
                cor_next.y     = ys - (xs >>> i);
                cor_next.phase = cor_reg[i].phase + ATAN_TURNS[i];
            end
            else
            begin
                cor_next.x     = xs - (ys >>> i);
                cor_next.y     = ys + (xs >>> i);
                cor_next.phase = cor_reg[i].phase - ATAN_TURNS[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en[i+1])
            begin
                cor_reg[i+1] <= cor_next;
            end
        end
    end

    // gain compensation multiply
    logic signed [DATA_W-1:0] xf;
    logic [MAG_IN_W-1:0]      mag_in;

    always_comb
    begin
        xf     = cor_reg[CORDIC_STAGES].x;
        mag_in = xf[DATA_W-1] ? '0 : xf[MAG_SHIFT+MAG_IN_W-1:MAG_SHIFT];

        mul_next.prod    = {{GAIN_W{1'b0}}, mag_in} * {{MAG_IN_W{1'b0}}, INV_GAIN_Q32};
        mul_next.big     = !xf[DATA_W-1] && (|xf[DATA_W-2:MAG_SHIFT+MAG_IN_W]);
        mul_next.phase   = cor_reg[CORDIC_STAGES].phase;
        mul_next.special = cor_reg[CORDIC_STAGES].special;
        mul_next.dy_pos  = cor_reg[CORDIC_STAGES].dy_pos;
        mul_next.abs_dy  = cor_reg[CORDIC_STAGES].abs_dy;
    end

    always_ff @(posedge clk)
    begin
        if (en[MUL_IDX])
        begin
            mul_reg <= mul_next;
        end
    end

    // rounding, saturation and the zero dx case
    logic [PROD_W:0]        rnd;
    logic [MAG_W:0]         mag_full;
    logic [PHASE_W-1:0]     ph_rnd;

    always_comb
    begin
        rnd      = {1'b0, mul_reg.prod} + ((PROD_W+1)'(1) << (ROUND_SHIFT - 1));
        mag_full = rnd[ROUND_SHIFT+MAG_W:ROUND_SHIFT];
        ph_rnd   = mul_reg.phase + PHASE_ROUND;

        if (mul_reg.special)
        begin
            polar_next.magnitude = mul_reg.abs_dy;
            polar_next.angle     = mul_reg.dy_pos ? ANGLE_QUARTER : ANGLE_3QUART;
        end
        else
        begin
            polar_next.magnitude = (mul_reg.big || mag_full[MAG_W]) ? MAG_MAX
                                                                    : mag_full[MAG_W-1:0];
            polar_next.angle     = ph_rnd[PHASE_W-1:PHASE_W-ANGLE_W];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[OUT_IDX])
        begin
            polar_reg <= polar_next;
        end
    end

    assign points_ready = en[0];
    assign polar_valid  = vld_reg[OUT_IDX];
    assign polar        = polar_reg;

endmodule

// ===== hw/rtl/ctpv_checker.sv =====
// port-level checker for the cartesian to polar vector core, with its bind
// depends on ctpv_pkg and cartesian_to_polar_vector_core_assert.svh
`include "cartesian_to_polar_vector_core_assert.svh"

module ctpv_checker
    import ctpv_pkg::*;
#(
    parameter int CORDIC_STAGES = 16
)
(
    input logic   clk,
    input logic   rst_n,
    input logic   points_valid,
    input logic   points_ready,
    input logic   polar_valid,
    input logic   polar_ready,
    input polar_t polar
);

    localparam int               DEPTH     = CORDIC_STAGES + 3;
    localparam int               CNT_W     = $clog2(DEPTH + 1) + 1;
    localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;
    logic             in_fire;
    logic             out_fire;

    // items taken in and not yet delivered
    assign in_fire    = points_valid && points_ready;
    assign out_fire   = polar_valid && polar_ready;
    assign count_next = count_reg + CNT_W'(in_fire) - CNT_W'(out_fire);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    `CTPV_ASSERT_HOLDS(a_reset_empty, !$past(rst_n) |-> !polar_valid, "result valid after reset")
    `CTPV_ASSERT_NEXT(a_out_hold, polar_valid && !polar_ready, polar_valid && $stable(polar), "stalled result changed")
    `CTPV_ASSERT_HOLDS(a_no_orphan, polar_valid |-> (count_reg != '0), "result without an item")
    `CTPV_ASSERT_HOLDS(a_full_stalls, (count_reg == DEPTH_CNT) && !polar_ready |-> !points_ready, "item taken while full")

endmodule

bind cartesian_to_polar_vector_core ctpv_checker #(
    .CORDIC_STAGES (CORDIC_STAGES)
) u_ctpv_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .points_valid (points_valid),
    .points_ready (points_ready),
    .polar_valid  (polar_valid),
    .polar_ready  (polar_ready),
    .polar        (polar)
);
